>>> rtl/servo_position_loop_defines.svh
// Assertion macros shared by the servo position loop RTL.
`ifndef SERVO_POSITION_LOOP_DEFINES_SVH
`define SERVO_POSITION_LOOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SPL_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spl_pkg.sv
// Package for the servo position loop: widths, constants, state and register codes.
package spl_pkg;

    // Field widths
    localparam int ANGLE_W   = 12;
    localparam int TARGET_W  = 18;
    localparam int POS_W     = 30;
    localparam int OFFSET_W  = 21;
    localparam int GAIN_W    = 8;
    localparam int PWM_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 21;

    // Default turn counter width
    localparam int TURN_BITS_DEF = 12;

    // Wrap detection thresholds on the encoder angle
    localparam int WRAP_HI = 4000;
    localparam int WRAP_LO = 100;

    // One encoder count is 45/512 degree
    localparam int POS_SCALE = 45;

    // Drive magnitude = |gain * error| / 8192, rounded half away from zero
    localparam int DUTY_SHIFT = 13;
    localparam int ROUND_BIAS = 4096;
    localparam int DUTY_MAX   = 255;

    // Register reset values
    localparam int RST_PROP_GAIN    = 32;
    localparam int RST_STALL_BOOST  = 15;
    localparam int RST_TARGET_UPPER = 15360;
    localparam int RST_TARGET_LOWER = -46080;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_OFFSET     = 3'd0,
        CFG_COUNT_DIRECTION = 3'd1,
        CFG_PROP_GAIN       = 3'd2,
        CFG_STALL_BOOST     = 3'd3,
        CFG_TARGET_UPPER    = 3'd4,
        CFG_TARGET_LOWER    = 3'd5
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAW,
        ST_POS,
        ST_ERR,
        ST_PROD,
        ST_DUTY
    } spl_state_t;

endpackage

>>> rtl/servo_position_loop.sv
// Multi-turn encoder position loop with proportional H-bridge drive.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid/s_ready, s_encoder_angle,       | in
//          | s_target_position                       |
//  result  | m_valid/m_ready, m_drive_enable,        | out
//          | m_pwm_forward, m_pwm_reverse, m_position|
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data| in
//
// An input beat passes through the steps RAW, POS, ERR, PROD and DUTY before its
// result beat is offered; no new input beat is taken until the sequencer is back in
// IDLE, so one item is in flight at a time. The steps come from one shared multiplier,
// used once to scale the raw count to 1/512 degree and once to apply the gain, plus
// the steps around it. A stalled result beat holds the sequencer in its last step until taken.
// Reset (aresetn low, synchronous) clears turn count and last angle and loads the
// register defaults. Configuration beats are always taken (cfg_ready high).
module servo_position_loop
    import spl_pkg::*;
#(
    parameter int TURN_BITS = TURN_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [ANGLE_W-1:0]         s_encoder_angle,
    input  logic signed [TARGET_W-1:0] s_target_position,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_drive_enable,
    output logic [PWM_W-1:0]           m_pwm_forward,
    output logic [PWM_W-1:0]           m_pwm_reverse,
    output logic signed [POS_W-1:0]    m_position,
    // configuration channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

`include "servo_position_loop_defines.svh"

    // Derived widths
    localparam int TB_W    = TURN_BITS + ANGLE_W;
    localparam int RAW_W   = ((TB_W > OFFSET_W) ? TB_W : OFFSET_W) + 1;
    localparam int ERR_W   = POS_W + 1;
    localparam int MUL_A_W = (RAW_W > ERR_W) ? RAW_W : ERR_W;
    localparam int MUL_B_W = GAIN_W + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic signed [TURN_BITS-1:0] TC_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TC_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] POS_HI = PROD_W'(2**(POS_W-1) - 1);
    localparam logic signed [PROD_W-1:0] POS_LO = PROD_W'(-(2**(POS_W-1)));

    // Configuration registers
    logic signed [OFFSET_W-1:0] zero_offset_reg;
    logic                       count_direction_reg;
    logic [GAIN_W-1:0]          prop_gain_reg;
    logic [PWM_W-1:0]           stall_boost_reg;
    logic signed [TARGET_W-1:0] target_upper_reg;
    logic signed [TARGET_W-1:0] target_lower_reg;

    // Control state
    spl_state_t                 state_reg, state_next;
    logic [ANGLE_W-1:0]         last_angle_reg, last_angle_next;
    logic signed [TURN_BITS-1:0] turn_count_reg, turn_count_next;
    logic                       m_valid_reg, m_valid_next;

    // Datapath registers
    logic [ANGLE_W-1:0]         angle_reg, angle_next;
    logic signed [TARGET_W-1:0] target_reg, target_next;
    logic                       stalled_reg, stalled_next;
    logic signed [RAW_W-1:0]    raw_reg, raw_next;
    logic signed [POS_W-1:0]    pos_reg, pos_next;
    logic signed [ERR_W-1:0]    err_reg, err_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [PWM_W-1:0]           fwd_reg, fwd_next;
    logic [PWM_W-1:0]           rev_reg, rev_next;
    logic signed [POS_W-1:0]    out_pos_reg, out_pos_next;

    // Shared multiplier
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;

    // Helpers
    logic                       in_beat;
    logic                       wrap_up, wrap_dn;
    logic signed [RAW_W-1:0]    raw_sum, zo_ext;
    logic [PROD_W-1:0]          mag, rounded, duty_sum;
    logic [PWM_W-1:0]           duty;
    logic                       prod_zero;

    assign in_beat        = s_valid && s_ready;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_drive_enable = 1'b1;
    assign m_pwm_forward  = fwd_reg;
    assign m_pwm_reverse  = rev_reg;
    assign m_position     = out_pos_reg;
    assign cfg_ready      = 1'b1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_offset_reg     <= '0;
            count_direction_reg <= 1'b1;
            prop_gain_reg       <= GAIN_W'(RST_PROP_GAIN);
            stall_boost_reg     <= PWM_W'(RST_STALL_BOOST);
            target_upper_reg    <= TARGET_W'(RST_TARGET_UPPER);
            target_lower_reg    <= TARGET_W'(RST_TARGET_LOWER);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ZERO_OFFSET:     zero_offset_reg     <= OFFSET_W'(cfg_data);
                CFG_COUNT_DIRECTION: count_direction_reg <= cfg_data[0];
                CFG_PROP_GAIN:       prop_gain_reg       <= cfg_data[GAIN_W-1:0];
                CFG_STALL_BOOST:     stall_boost_reg     <= cfg_data[PWM_W-1:0];
                CFG_TARGET_UPPER:    target_upper_reg    <= cfg_data[TARGET_W-1:0];
                CFG_TARGET_LOWER:    target_lower_reg    <= cfg_data[TARGET_W-1:0];
                default: ;
            endcase
        end
    end

    // Turn wrap detection on the incoming angle
    assign wrap_up = (last_angle_reg > ANGLE_W'(WRAP_HI)) &&
                     (s_encoder_angle < ANGLE_W'(WRAP_LO));
    assign wrap_dn = (last_angle_reg < ANGLE_W'(WRAP_LO)) &&
                     (s_encoder_angle > ANGLE_W'(WRAP_HI));

    // Raw count with offset and direction
    assign raw_sum = (RAW_W'(turn_count_reg) <<< ANGLE_W) +
                     RAW_W'($signed({1'b0, angle_reg}));
    assign zo_ext  = RAW_W'(zero_offset_reg);

    // Shared multiplier operand select
    always_comb begin
        if (state_reg == ST_PROD) begin
            mul_a = MUL_A_W'(err_reg);
            mul_b = $signed({2'b00, prop_gain_reg});
        end else begin
            mul_a = MUL_A_W'(raw_reg);
            mul_b = MUL_B_W'(POS_SCALE);
        end
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Duty: magnitude, rounding, stall boost, saturation
    assign prod_zero = (prod_reg == '0);
    assign mag       = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign rounded   = (mag + PROD_W'(ROUND_BIAS)) >> DUTY_SHIFT;
    assign duty_sum  = rounded + (stalled_reg ? PROD_W'(stall_boost_reg) : '0);
    always_comb begin
        if (prod_zero) begin
            duty = '0;
        end else if (duty_sum > PROD_W'(DUTY_MAX)) begin
            duty = PWM_W'(DUTY_MAX);
        end else begin
            duty = duty_sum[PWM_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        last_angle_next = last_angle_reg;
        turn_count_next = turn_count_reg;
        m_valid_next    = m_valid_reg;
        angle_next      = angle_reg;
        target_next     = target_reg;
        stalled_next    = stalled_reg;
        raw_next        = raw_reg;
        pos_next        = pos_reg;
        err_next        = err_reg;
        prod_next       = prod_reg;
        fwd_next        = fwd_reg;
        rev_next        = rev_reg;
        out_pos_next    = out_pos_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    // turn count, stall flag and target clamp
                    if (wrap_up && (turn_count_reg < TC_MAX)) begin
                        turn_count_next = turn_count_reg + 1'b1;
                    end else if (wrap_dn && (turn_count_reg > TC_MIN)) begin
                        turn_count_next = turn_count_reg - 1'b1;
                    end
                    stalled_next    = (s_encoder_angle == last_angle_reg);
                    last_angle_next = s_encoder_angle;
                    angle_next      = s_encoder_angle;
                    if (s_target_position > target_upper_reg) begin
                        target_next = target_upper_reg;
                    end else if (s_target_position < target_lower_reg) begin
                        target_next = target_lower_reg;
                    end else begin
                        target_next = s_target_position;
                    end
                    state_next = ST_RAW;
                end
            end
            ST_RAW: begin
                raw_next   = count_direction_reg ? (raw_sum - zo_ext) : (zo_ext - raw_sum);
                state_next = ST_POS;
            end
            ST_POS: begin
                // scale to 1/512 degree and saturate
                if (mul_p > POS_HI) begin
                    pos_next = POS_HI[POS_W-1:0];
                end else if (mul_p < POS_LO) begin
                    pos_next = POS_LO[POS_W-1:0];
                end else begin
                    pos_next = mul_p[POS_W-1:0];
                end
                state_next = ST_ERR;
            end
            ST_ERR: begin
                err_next   = ERR_W'(target_reg) - ERR_W'(pos_reg);
                state_next = ST_PROD;
            end
            ST_PROD: begin
                prod_next  = mul_p;
                state_next = ST_DUTY;
            end
            ST_DUTY: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    if (!prod_reg[PROD_W-1] && !prod_zero) begin
                        fwd_next = duty;
                        rev_next = '0;
                    end else begin
                        fwd_next = '0;
                        rev_next = duty;
                    end
                    out_pos_next = pos_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            last_angle_reg <= '0;
            turn_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            last_angle_reg <= last_angle_next;
            turn_count_reg <= turn_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        angle_reg   <= angle_next;
        target_reg  <= target_next;
        stalled_reg <= stalled_next;
        raw_reg     <= raw_next;
        pos_reg     <= pos_next;
        err_reg     <= err_next;
        prod_reg    <= prod_next;
        fwd_reg     <= fwd_next;
        rev_reg     <= rev_next;
        out_pos_reg <= out_pos_next;
    end

    // Checks
    `SPL_ASSERT_IMPLY(a_busy_not_ready, aclk, aresetn, state_reg != ST_IDLE, !s_ready, "input ready while busy")
    `SPL_ASSERT_NEXT(a_beat_starts, aclk, aresetn, in_beat, state_reg == ST_RAW, "accepted beat did not start sequence")
    `SPL_ASSERT_NEXT(a_duty_holds, aclk, aresetn, (state_reg == ST_DUTY) && m_valid_reg && !m_ready, (state_reg == ST_DUTY) && $stable(fwd_reg) && $stable(rev_reg), "pending result overwritten")
    `SPL_ASSERT_IMPLY(a_one_leg, aclk, aresetn, m_valid_reg, (fwd_reg == '0) || (rev_reg == '0), "both bridge legs driven")

endmodule
